>>> rtl/core/c4f_pkg.sv
// Shared constants, codes, types and a helper function of the C4-free edge insert block.
`default_nettype none
package c4f_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int NROWS_W    = $clog2(MAX_ROWS + 1);
   localparam int NCOLS_W    = $clog2(MAX_COLS + 1);
   localparam int VERT_W     = 6;
   localparam int SIZE_W     = 7;
   localparam int CNT_W      = 13;
   localparam int OUTCOME_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SIZE_W;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'b1;

   localparam logic [OUTCOME_W-1:0] OUT_PRESENT  = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_ADDED    = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_REJECTED = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_RANGE    = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_CLEARED  = 3'd4;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [CNT_W-1:0]     edge_total;
   } result_type;

   typedef struct packed {
      logic [SIZE_W-1:0] rows_in_use;
      logic [SIZE_W-1:0] cols_in_use;
   } sizes_type;

   function automatic logic [MAX_COLS-1:0] cols_mask(input logic [NCOLS_W-1:0] ncols);
      logic [MAX_COLS-1:0] m;
      for (int i = 0; i < MAX_COLS; i++) begin
         m[i] = (i < int'(ncols));
      end
      return m;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/c4f_req_if.sv
// Request channel interface: operation and edge vertices with valid/ready.
`default_nettype none
interface c4f_req_if
   import c4f_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              func;
   logic [VERT_W-1:0] row_vertex;
   logic [VERT_W-1:0] col_vertex;

   modport source (output valid, output func, output row_vertex, output col_vertex,
                   input ready);
   modport sink   (input valid, input func, input row_vertex, input col_vertex,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/core/c4f_rsp_if.sv
// Response channel interface: outcome code and edge count with valid/ready.
`default_nettype none
interface c4f_rsp_if
   import c4f_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic [CNT_W-1:0]     edge_total;

   modport source (output valid, output outcome, output edge_total, input ready);
   modport sink   (input valid, input outcome, input edge_total, output ready);
endinterface
`default_nettype wire

>>> rtl/core/c4_free_greedy_edge_insert.sv
// Top level of the C4-free greedy edge insert block: size registers and response stage.
`default_nettype none
// The block keeps a bipartite adjacency matrix in a row-wide synchronous memory and answers
// one request at a time. A clear request or an out-of-range edge goes from acceptance
// straight to the response register, an edge that is already present is found when its
// own row is read, and every other try-add scans the nrows rows in use, nrows being the
// effective row count: the cycle test reads each row in use at most once through the
// memory's single read port. Rows carry valid bits that reset and clear requests drop
// at once, so no clearing pass is needed and a request can be taken in the first cycle
// after reset. A finished response waits in its output register while the next request is accepted.
module c4_free_greedy_edge_insert
   import c4f_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   c4f_req_if.sink                    req_ch,
   c4f_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   sizes_type  sizes_ff, sizes_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   logic       res_valid;
   result_type res;
   logic       res_take;

   c4f_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .sizes    (sizes_ff),
      .res_valid(res_valid),
      .res      (res),
      .res_take (res_take)
   );

   assign res_take          = res_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.outcome    = rsp_data_ff.outcome;
   assign rsp_ch.edge_total = rsp_data_ff.edge_total;

   always_comb begin
      sizes_in = sizes_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: sizes_in.rows_in_use = csr_wdata;
            CSR_COLS_IN_USE: sizes_in.cols_in_use = csr_wdata;
            default: sizes_in = sizes_ff;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sizes_ff     <= '{rows_in_use: SIZE_W'(64), cols_in_use: SIZE_W'(64)};
         rsp_valid_ff <= 1'b0;
      end else begin
         sizes_ff     <= sizes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/c4f_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module c4f_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/c4f_engine.sv
// Sequencer that tests and inserts one edge by scanning the adjacency memory row by row, and clears the matrix.
`default_nettype none
module c4f_engine
   import c4f_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   c4f_req_if.sink         req_ch,
   input  wire sizes_type  sizes,
   output logic            res_valid,
   output result_type      res,
   input  wire logic       res_take
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ROWRD  = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [MAX_ROWS-1:0] row_valid_ff, row_valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rd_valid_ff;
   logic [ROW_W-1:0]    r_ff, r_in;
   logic [COL_W-1:0]    c_ff, c_in;
   logic [NROWS_W-1:0]  nrows_ff, nrows_in;
   logic [NCOLS_W-1:0]  ncols_ff, ncols_in;
   logic [NROWS_W-1:0]  ptr_ff, ptr_in;
   logic [MAX_COLS-1:0] mask_ff, mask_in;
   logic [MAX_COLS-1:0] row_ff, row_in;
   result_type          res_ff, res_in;

   logic                rd_en;
   logic [ROW_W-1:0]    rd_addr;
   logic [MAX_COLS-1:0] ram_q;
   logic [MAX_COLS-1:0] q_row;
   logic [MAX_COLS-1:0] c_bit;
   logic                wr_en;
   logic                accept;
   logic [NROWS_W-1:0]  eff_rows;
   logic [NCOLS_W-1:0]  eff_cols;
   logic                in_range;

   c4f_ram #(.DEPTH(MAX_ROWS), .WIDTH(MAX_COLS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (r_ff),
      .wr_data (row_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign q_row        = rd_valid_ff ? ram_q : '0;
   assign c_bit        = MAX_COLS'(1) << c_ff;
   assign res_valid    = (state_ff == ST_RESULT);
   assign res          = res_ff;

   always_comb begin
      eff_rows = (int'(sizes.rows_in_use) > MAX_ROWS) ? NROWS_W'(MAX_ROWS)
                                                      : NROWS_W'(sizes.rows_in_use);
      eff_cols = (int'(sizes.cols_in_use) > MAX_COLS) ? NCOLS_W'(MAX_COLS)
                                                      : NCOLS_W'(sizes.cols_in_use);
      in_range = (int'(req_ch.row_vertex) < int'(eff_rows)) &&
                 (int'(req_ch.col_vertex) < int'(eff_cols));
   end

   always_comb begin
      state_in     = state_ff;
      row_valid_in = row_valid_ff;
      count_in     = count_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      nrows_in     = nrows_ff;
      ncols_in     = ncols_ff;
      ptr_in       = ptr_ff;
      mask_in      = mask_ff;
      row_in       = row_ff;
      res_in       = res_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[ROW_W-1:0];
      wr_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.func == FUNC_CLEAR) begin
                  row_valid_in = '0;
                  count_in     = '0;
                  res_in       = '{outcome: OUT_CLEARED, edge_total: '0};
                  state_in     = ST_RESULT;
               end else if (!in_range) begin
                  res_in   = '{outcome: OUT_RANGE, edge_total: count_ff};
                  state_in = ST_RESULT;
               end else begin
                  r_in     = ROW_W'(req_ch.row_vertex);
                  c_in     = COL_W'(req_ch.col_vertex);
                  nrows_in = eff_rows;
                  ncols_in = eff_cols;
                  rd_en    = 1'b1;
                  rd_addr  = ROW_W'(req_ch.row_vertex);
                  state_in = ST_ROWRD;
               end
            end
         end
         ST_ROWRD: begin
            if ((q_row & c_bit) != '0) begin
               res_in   = '{outcome: OUT_PRESENT, edge_total: count_ff};
               state_in = ST_RESULT;
            end else begin
               mask_in  = q_row & cols_mask(ncols_ff) & ~c_bit;
               row_in   = q_row | c_bit;
               rd_en    = 1'b1;
               rd_addr  = '0;
               ptr_in   = NROWS_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (((q_row & c_bit) != '0) && ((q_row & mask_ff) != '0)) begin
               res_in   = '{outcome: OUT_REJECTED, edge_total: count_ff};
               state_in = ST_RESULT;
            end else if (ptr_ff == nrows_ff) begin
               state_in = ST_WRITE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[ROW_W-1:0];
               ptr_in  = ptr_ff + NROWS_W'(1);
            end
         end
         ST_WRITE: begin
            wr_en              = 1'b1;
            row_valid_in[r_ff] = 1'b1;
            count_in           = count_ff + CNT_W'(1);
            res_in             = '{outcome: OUT_ADDED, edge_total: count_ff + CNT_W'(1)};
            state_in           = ST_RESULT;
         end
         ST_RESULT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         count_ff     <= count_in;
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      c_ff     <= c_in;
      nrows_ff <= nrows_in;
      ncols_ff <= ncols_in;
      ptr_ff   <= ptr_in;
      mask_ff  <= mask_in;
      row_ff   <= row_in;
      res_ff   <= res_in;
   end
endmodule
`default_nettype wire

>>> rtl/core/c4f_checker.sv
// Port-level assertions for the C4-free edge insert block and their binding to the top level.
`default_nettype none
module c4f_checker
   import c4f_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [OUTCOME_W-1:0] outcome,
   input wire logic [CNT_W-1:0]     edge_total
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(outcome) && $stable(edge_total))
      else $error("Stalled response changed or dropped.");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outcome == OUT_PRESENT) || (outcome == OUT_ADDED) ||
                    (outcome == OUT_REJECTED) || (outcome == OUT_RANGE) ||
                    (outcome == OUT_CLEARED))
      else $error("Response carries an unknown outcome code.");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (outcome == OUT_CLEARED) |-> edge_total == '0)
      else $error("Clear response reports a nonzero edge count.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request accepted in two consecutive cycles.");
endmodule

bind c4_free_greedy_edge_insert c4f_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .outcome   (rsp_ch.outcome),
   .edge_total(rsp_ch.edge_total)
);
`default_nettype wire
